@@ hdl/sttr_pkg.sv @@
// ----------------------------------------------------------------------------
// sttr_pkg
// Shared types and constants for the sparse triplet transpose block.
// ----------------------------------------------------------------------------
package sttr_pkg;

  // default sizes
  localparam int MaxTermsDef = 32;
  localparam int MaxDimDef   = 256;

  // field widths
  localparam int DimW    = 9;
  localparam int IdxW    = 8;
  localparam int ValW    = 32;
  localparam int CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNumRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumCols = 2'd1;

  // input commands
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // one stored term
  typedef struct packed {
    logic [ValW-1:0] value;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] row;
  } term_t;

  // one result item
  typedef struct packed {
    logic            is_header;
    logic [DimW-1:0] out_row;
    logic [DimW-1:0] out_col;
    logic [ValW-1:0] out_value;
    logic            last;
  } result_t;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCheck,
    StFlush
  } state_e;

endpackage

@@ hdl/sttr_store.sv @@
// ----------------------------------------------------------------------------
// sttr_store
// Term store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sttr_store #(
  parameter int MaxTerms = sttr_pkg::MaxTermsDef,
  parameter int AddrW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  sttr_pkg::term_t   wr_term_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output sttr_pkg::term_t   rd_term_o
);
  import sttr_pkg::*;

  term_t mem [MaxTerms];
  term_t rd_term_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_term_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_term_q <= mem[rd_addr_i];
    end
  end

  assign rd_term_o = rd_term_q;

endmodule

@@ hdl/sttr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sttr_ctrl
// Load sequencing, column scan over the term store and result buffering.
// ----------------------------------------------------------------------------
module sttr_ctrl #(
  parameter int MaxTerms = sttr_pkg::MaxTermsDef,
  parameter int MaxDim   = sttr_pkg::MaxDimDef,
  parameter int AddrW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_cmd_i,
  input  sttr_pkg::term_t            in_term_i,
  input  logic [sttr_pkg::DimW-1:0]  num_rows_i,
  input  logic [sttr_pkg::DimW-1:0]  num_cols_i,
  output logic                       wr_en_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output sttr_pkg::term_t            wr_term_o,
  output logic                       rd_en_o,
  output logic [AddrW-1:0]           rd_addr_o,
  input  sttr_pkg::term_t            rd_term_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sttr_pkg::result_t          out_res_o
);
  import sttr_pkg::*;

  localparam int CntW = $clog2(MaxTerms + 1);
  localparam int ColW = $clog2(MaxDim);

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q;
  logic [AddrW-1:0]    j_q;
  logic [ColW-1:0]     c_q;
  result_t             pend_q;
  result_t             out_q, out_d;
  logic                out_valid_q;

  logic [DimW-1:0]     bound;
  logic                full, empty_run, j_last, c_last, hit, out_free;
  logic                load_en, finish_start, advance, push, flush_done;

  // scan bound capped at the column range
  assign bound = (num_cols_i > DimW'(MaxDim)) ? DimW'(MaxDim) : num_cols_i;

  assign full      = (count_q == CntW'(MaxTerms));
  assign empty_run = (count_q == '0) || (bound == '0);
  assign j_last    = ((CntW'(j_q) + CntW'(1)) == count_q);
  assign c_last    = ((DimW'(c_q) + DimW'(1)) == bound);
  assign hit       = ({1'b0, rd_term_i.col} == DimW'(c_q));
  assign out_free  = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && (in_cmd_i == CmdFinish)) begin
          state_d = empty_run ? StFlush : StRead;
        end
      end
      StRead: begin
        state_d = StCheck;
      end
      StCheck: begin
        if (!hit || out_free) begin
          state_d = (j_last && c_last) ? StFlush : StRead;
        end
      end
      StFlush: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o   = (state_q == StIdle);
    load_en      = 1'b0;
    finish_start = 1'b0;
    rd_en_o      = 1'b0;
    advance      = 1'b0;
    push         = 1'b0;
    flush_done   = 1'b0;
    unique case (state_q)
      StIdle: begin
        load_en      = in_valid_i && (in_cmd_i == CmdLoad) && !full;
        finish_start = in_valid_i && (in_cmd_i == CmdFinish);
      end
      StRead: begin
        rd_en_o = 1'b1;
      end
      StCheck: begin
        advance = !hit || out_free;
        push    = hit && out_free;
      end
      StFlush: begin
        flush_done = out_free;
      end
      default: ;
    endcase
  end

  // store ports; loads and scan reads never overlap
  assign wr_en_o   = load_en;
  assign wr_addr_o = count_q[AddrW-1:0];
  assign wr_term_o = in_term_i;
  assign rd_addr_o = j_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // term count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (flush_done) begin
      count_q <= '0;
    end else if (load_en) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // scan counters: term index inner, column outer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
      c_q <= '0;
    end else if (finish_start) begin
      j_q <= '0;
      c_q <= '0;
    end else if (advance) begin
      if (j_last) begin
        j_q <= '0;
        c_q <= c_q + ColW'(1);
      end else begin
        j_q <= j_q + AddrW'(1);
      end
    end
  end

  // pending result, held back one step so the final one can be marked
  always_ff @(posedge clk_i) begin
    if (finish_start) begin
      pend_q.is_header <= 1'b1;
      pend_q.out_row   <= num_cols_i;
      pend_q.out_col   <= num_rows_i;
      pend_q.out_value <= ValW'(count_q);
      pend_q.last      <= 1'b0;
    end else if (push) begin
      pend_q.is_header <= 1'b0;
      pend_q.out_row   <= {1'b0, rd_term_i.col};
      pend_q.out_col   <= {1'b0, rd_term_i.row};
      pend_q.out_value <= rd_term_i.value;
      pend_q.last      <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push || flush_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // pending result with the last flag set on the closing transfer
  always_comb begin
    out_d      = pend_q;
    out_d.last = flush_done;
  end

  always_ff @(posedge clk_i) begin
    if (push || flush_done) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

@@ hdl/sparse_triplet_transpose.sv @@
// ----------------------------------------------------------------------------
// sparse_triplet_transpose
// Collects sparse matrix terms and streams out the transpose on finish.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                     payload
//  s_axis    in    s_axis_tvalid/s_axis_tready   tuser command, tdata term
//  m_axis    out   m_axis_tvalid/m_axis_tready   tuser is_header, tdata, tlast
//  cfg       in    cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
//  a load writes the term to the store at once; a load into a full store is dropped
//  finish walks every (column, stored term) pair: a read state and a
//  compare state per pair on the single read port, then a flush state to close
//  no input transfer is taken while a finish run is in progress
//  a stalled output holds the scan at the next matching term
//  reset clears the term count and both registers; the store needs no clearing
// ----------------------------------------------------------------------------
module sparse_triplet_transpose #(
  parameter int MaxTerms = sttr_pkg::MaxTermsDef,
  parameter int MaxDim   = sttr_pkg::MaxDimDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input terms
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,   // row_index, col_index, term_value
  input  logic                          s_axis_tuser,   // command
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,   // out_row, out_col, out_value, zeros
  output logic                          m_axis_tuser,   // is_header
  output logic                          m_axis_tlast,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sttr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sttr_pkg::DimW-1:0]     cfg_data_i
);
  import sttr_pkg::*;

  localparam int AddrW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;

  logic [DimW-1:0]  num_rows_q, num_cols_q;
  term_t            in_term, wr_term, rd_term;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  result_t          out_res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= '0;
      num_cols_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumRows: num_rows_q <= cfg_data_i;
        CfgNumCols: num_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack input term
  assign in_term.row   = s_axis_tdata[7:0];
  assign in_term.col   = s_axis_tdata[15:8];
  assign in_term.value = s_axis_tdata[47:16];

  sttr_ctrl #(
    .MaxTerms (MaxTerms),
    .MaxDim   (MaxDim),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_term_i   (in_term),
    .num_rows_i  (num_rows_q),
    .num_cols_i  (num_cols_q),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_term_o   (wr_term),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_term_i   (rd_term),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  sttr_store #(
    .MaxTerms (MaxTerms),
    .AddrW    (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_term_i (wr_term),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_term_o (rd_term)
  );

  // pack result
  assign m_axis_tdata = {6'b0, out_res.out_value, out_res.out_col, out_res.out_row};
  assign m_axis_tuser = out_res.is_header;
  assign m_axis_tlast = out_res.last;

endmodule
